>>> hw/rtl/mpe_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Mask palette expander package
// Shared types, constants and the mask search function.
// ----------------------------------------------------------------------------
package mpe_pkg;

    localparam int PALETTES_PER_LINE = 3;
    localparam int WORD_W            = 16;
    localparam int POS_W             = 4;
    localparam int PAL_W             = 2;
    localparam int QUEUE_DEPTH       = 2;
    localparam logic [POS_W-1:0] LAST_POS = 4'd15;

    typedef struct packed {
        logic              is_header;
        logic [WORD_W-1:0] word;
    } t_cmd;

    typedef struct packed {
        logic [WORD_W-1:0] entry_value;
        logic [PAL_W-1:0]  palette_select;
        logic [POS_W-1:0]  entry_position;
        logic              line_done;
    } t_result;

    typedef struct packed {
        logic             found;
        logic [POS_W-1:0] idx;
    } t_search;

    // Lowest set mask bit at or above the given position, position fifteen excluded.
    function automatic t_search first_set(input logic [WORD_W-1:0] mask,
                                          input logic [POS_W:0]    from);
        t_search res;
        res.found = 1'b0;
        res.idx   = '0;
        for (int i = 0; i < WORD_W - 1; i++) begin
            if (!res.found && (5'(i) >= from) && mask[i]) begin
                res.found = 1'b1;
                res.idx   = POS_W'(i);
            end
        end
        return res;
    endfunction

endpackage

>>> hw/rtl/mask_palette_expander_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Mask palette expander
// Expands mask-compressed scan-line palettes into tagged 16-bit entries.
// ----------------------------------------------------------------------------
// The queue and the output stage are registered between an accepted word and its first result.
// The expander gives one result per cycle while its output stage is empty or popped.
// A two-entry command queue lets input words be taken while the expander is busy.
// Reset is synchronous and clears the queue, the stream position and the output stage.
module mask_palette_expander_top #(
    parameter int P_PALETTES = mpe_pkg::PALETTES_PER_LINE
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            push,
    output logic                            full,
    input  logic [mpe_pkg::WORD_W-1:0]      i_word_in,
    input  logic                            pop,
    output logic                            empty,
    output logic [mpe_pkg::WORD_W-1:0]      o_entry_value,
    output logic [mpe_pkg::PAL_W-1:0]       o_palette_select,
    output logic [mpe_pkg::POS_W-1:0]       o_entry_position,
    output logic                            o_line_done
);

    mpe_pkg::t_cmd      front_cmd;
    mpe_pkg::t_cmd      queue_cmd;
    mpe_pkg::t_result   result;
    logic               accept;
    logic               queue_valid;
    logic               queue_pop;
    logic               out_valid;

    assign accept = push && !full;

    mpe_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_word   (i_word_in),
        .o_cmd    (front_cmd)
    );

    mpe_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .o_full  (full),
        .i_pop   (queue_pop),
        .o_valid (queue_valid),
        .o_cmd   (queue_cmd)
    );

    mpe_back #(
        .P_PALETTES (P_PALETTES)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (queue_valid),
        .i_cmd       (queue_cmd),
        .o_cmd_pop   (queue_pop),
        .i_pop       (pop),
        .o_valid     (out_valid),
        .o_result    (result)
    );

    assign empty            = !out_valid;
    assign o_entry_value    = result.entry_value;
    assign o_palette_select = result.palette_select;
    assign o_entry_position = result.entry_position;
    assign o_line_done      = result.line_done;

    a_done_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_line_done) |->
            (o_entry_position == mpe_pkg::LAST_POS) &&
            (o_palette_select == mpe_pkg::PAL_W'(P_PALETTES - 1)))
        else $error("line flag away from the last entry of the line");

    a_pal_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (int'(o_palette_select) < P_PALETTES))
        else $error("palette index out of range");

    a_last_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && (o_entry_position == mpe_pkg::LAST_POS)) |-> (o_entry_value == '0))
        else $error("position fifteen carries a non-zero entry");

    a_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && pop && o_line_done) |=> (empty || (o_palette_select == '0)))
        else $error("palette index did not return to zero after a line");

endmodule

>>> hw/rtl/mpe_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Mask palette expander front end
// Tracks the stream position and tags each accepted word as header or entry.
// ----------------------------------------------------------------------------
module mpe_front (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_accept,
    input  logic [mpe_pkg::WORD_W-1:0]      i_word,
    output mpe_pkg::t_cmd                   o_cmd
);

    logic                           r_awaiting;
    logic [mpe_pkg::WORD_W-1:0]     r_mask;
    logic [mpe_pkg::POS_W-1:0]      r_pos;
    logic                           n_awaiting;
    logic [mpe_pkg::WORD_W-1:0]     n_mask;
    logic [mpe_pkg::POS_W-1:0]      n_pos;
    mpe_pkg::t_search               search;

    always_comb begin
        n_awaiting = r_awaiting;
        n_mask     = r_mask;
        n_pos      = r_pos;
        if (r_awaiting) begin
            search = mpe_pkg::first_set(i_word, '0);
        end else begin
            search = mpe_pkg::first_set(r_mask, {1'b0, r_pos} + 5'd1);
        end
        if (i_accept) begin
            if (r_awaiting) begin
                n_mask = i_word;
            end
            n_awaiting = !search.found;
            n_pos      = search.found ? search.idx : '0;
        end
    end

    assign o_cmd.is_header = r_awaiting;
    assign o_cmd.word      = i_word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_awaiting <= 1'b1;
            r_mask     <= '0;
            r_pos      <= '0;
        end else begin
            r_awaiting <= n_awaiting;
            r_mask     <= n_mask;
            r_pos      <= n_pos;
        end
    end

endmodule

>>> hw/rtl/mpe_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Mask palette expander command queue
// Short first-in first-out queue between the front end and the expander.
// ----------------------------------------------------------------------------
module mpe_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  mpe_pkg::t_cmd   i_cmd,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_valid,
    output mpe_pkg::t_cmd   o_cmd
);

    localparam int AW = $clog2(mpe_pkg::QUEUE_DEPTH);

    mpe_pkg::t_cmd  r_mem [mpe_pkg::QUEUE_DEPTH];
    logic [AW-1:0]  r_wr_ptr;
    logic [AW-1:0]  r_rd_ptr;
    logic [AW:0]    r_count;
    logic           do_push;
    logic           do_pop;

    assign o_full  = (r_count == (AW+1)'(mpe_pkg::QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == AW'(mpe_pkg::QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == AW'(mpe_pkg::QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            r_count <= r_count + (AW+1)'(do_push) - (AW+1)'(do_pop);
        end
    end

endmodule

>>> hw/rtl/mpe_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Mask palette expander back end
// Expands queued commands into palette entries, one result per cycle while the output is empty or popped.
// ----------------------------------------------------------------------------
module mpe_back #(
    parameter int P_PALETTES = mpe_pkg::PALETTES_PER_LINE
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cmd_valid,
    input  mpe_pkg::t_cmd       i_cmd,
    output logic                o_cmd_pop,
    input  logic                i_pop,
    output logic                o_valid,
    output mpe_pkg::t_result    o_result
);

    localparam logic [mpe_pkg::PAL_W-1:0] LAST_PAL = mpe_pkg::PAL_W'(P_PALETTES - 1);

    logic                           r_busy;
    logic [mpe_pkg::WORD_W-1:0]     r_mask;
    logic [mpe_pkg::POS_W-1:0]      r_pos;
    logic [mpe_pkg::PAL_W-1:0]      r_pal;
    logic                           r_out_valid;
    mpe_pkg::t_result               r_out;
    logic                           n_busy;
    logic [mpe_pkg::WORD_W-1:0]     n_mask;
    logic [mpe_pkg::POS_W-1:0]      n_pos;
    logic [mpe_pkg::PAL_W-1:0]      n_pal;
    logic                           n_out_valid;
    mpe_pkg::t_result               n_out;

    always_comb begin
        logic                       adv;
        logic                       emit;
        logic [mpe_pkg::WORD_W-1:0] ev;
        logic [mpe_pkg::POS_W-1:0]  ep;
        logic [mpe_pkg::POS_W-1:0]  np;
        logic [mpe_pkg::WORD_W-1:0] cur_mask;
        n_busy      = r_busy;
        n_mask      = r_mask;
        n_pos       = r_pos;
        n_pal       = r_pal;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        o_cmd_pop   = 1'b0;
        adv         = !r_out_valid || i_pop;
        emit        = 1'b0;
        ev          = '0;
        ep          = r_pos;
        np          = '0;
        cur_mask    = r_mask;
        if (adv) begin
            if (r_busy) begin
                emit = 1'b1;
            end else if (i_cmd_valid) begin
                o_cmd_pop = 1'b1;
                if (i_cmd.is_header) begin
                    cur_mask = i_cmd.word;
                    n_mask   = i_cmd.word;
                    n_pos    = '0;
                    ep       = '0;
                    emit     = !i_cmd.word[0];
                end else begin
                    emit = 1'b1;
                    ev   = i_cmd.word;
                end
            end
            n_out_valid = emit;
            if (emit) begin
                n_out.entry_value    = ev;
                n_out.palette_select = r_pal;
                n_out.entry_position = ep;
                n_out.line_done      = (ep == mpe_pkg::LAST_POS) && (r_pal == LAST_PAL);
                if (ep == mpe_pkg::LAST_POS) begin
                    n_pal  = (r_pal == LAST_PAL) ? '0 : r_pal + 1'b1;
                    n_busy = 1'b0;
                    n_pos  = '0;
                end else begin
                    np     = ep + 1'b1;
                    n_pos  = np;
                    n_busy = !((np != mpe_pkg::LAST_POS) && cur_mask[np]);
                end
            end
        end
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_mask      <= '0;
            r_pos       <= '0;
            r_pal       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_busy      <= n_busy;
            r_mask      <= n_mask;
            r_pos       <= n_pos;
            r_pal       <= n_pal;
            r_out_valid <= n_out_valid;
        end
        r_out <= n_out;
    end

endmodule
